// ----- design/ihd_pkg.sv -----
// ----------------------------------------------------------------------------
// ihd_pkg
// Shared types, codes and helpers for the cartridge header decoder.
// ----------------------------------------------------------------------------
package ihd_pkg;

	localparam int unsigned SIG_LEN   = 4;
	localparam int unsigned HDR_BYTES = 12;   // header bytes 4..15
	localparam int unsigned POS_W     = 4;
	localparam logic [POS_W-1:0] POS_LAST = 4'd15;

	localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [1:0] VER_ARCHAIC = 2'd0;
	localparam logic [1:0] VER_INES    = 2'd1;
	localparam logic [1:0] VER_NES2    = 2'd2;

	localparam logic [1:0] MIRROR_HORZ = 2'd0;
	localparam logic [1:0] MIRROR_VERT = 2'd1;
	localparam logic [1:0] MIRROR_FOUR = 2'd2;

	localparam logic [3:0] VER_MASK = 4'hC;
	localparam logic [3:0] VER_NES2_ID = 4'h8;

	localparam int unsigned RAM_W = 22;
	localparam logic [RAM_W-1:0] RAM_8K = 22'h2000;
	localparam logic [RAM_W-1:0] RAM_NES2_BASE = 22'd64;

	// Snapshot of a complete header: signature result and bytes 4..15
	typedef struct packed {
		logic                         sig_ok;
		logic [HDR_BYTES-1:0][7:0]    b;
	} hdr_t;

	typedef struct packed {
		logic             status;
		logic [1:0]       version;
		logic [11:0]      mapper;
		logic [3:0]       submapper;
		logic [25:0]      prg_rom_bytes;
		logic [24:0]      chr_rom_bytes;
		logic [RAM_W-1:0] prg_ram_bytes;
		logic [RAM_W-1:0] prg_nvram_bytes;
		logic [RAM_W-1:0] chr_ram_bytes;
		logic [RAM_W-1:0] chr_nvram_bytes;
		logic [1:0]       mirroring;
		logic [3:0]       flags;
	} res_t;

	// NES 2.0 RAM size: zero shift means no RAM, else 64 << shift
	function automatic logic [RAM_W-1:0] nes2_ram(input logic [3:0] shift);
		logic [RAM_W-1:0] sz;
		if (shift == 4'd0) begin
			sz = '0;
		end else begin
			sz = RAM_NES2_BASE << shift;
		end
		return sz;
	endfunction

endpackage

// ----- design/ihd_in_if.sv -----
// ----------------------------------------------------------------------------
// ihd_in_if
// Header byte channel: valid/ready with one byte and a start flag.
// ----------------------------------------------------------------------------
interface ihd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hdr_byte;
	logic       start_req;

	modport source (output valid, output hdr_byte, output start_req, input ready);
	modport sink   (input valid, input hdr_byte, input start_req, output ready);
endinterface

// ----- design/ihd_out_if.sv -----
// ----------------------------------------------------------------------------
// ihd_out_if
// Decoded header channel: valid/ready with the decoded fields.
// ----------------------------------------------------------------------------
interface ihd_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [1:0]  version;
	logic [11:0] mapper;
	logic [3:0]  submapper;
	logic [25:0] prg_rom_bytes;
	logic [24:0] chr_rom_bytes;
	logic [21:0] prg_ram_bytes;
	logic [21:0] prg_nvram_bytes;
	logic [21:0] chr_ram_bytes;
	logic [21:0] chr_nvram_bytes;
	logic [1:0]  mirroring;
	logic [3:0]  flags;

	modport source (
		output valid, output status, output version, output mapper, output submapper,
		output prg_rom_bytes, output chr_rom_bytes, output prg_ram_bytes,
		output prg_nvram_bytes, output chr_ram_bytes, output chr_nvram_bytes,
		output mirroring, output flags, input ready
	);
	modport sink (
		input valid, input status, input version, input mapper, input submapper,
		input prg_rom_bytes, input chr_rom_bytes, input prg_ram_bytes,
		input prg_nvram_bytes, input chr_ram_bytes, input chr_nvram_bytes,
		input mirroring, input flags, output ready
	);
endinterface

// ----- design/ines_header_decoder_top.sv -----
// Latency: the result is valid the cycle after header byte 15 is accepted.
// Throughput: one header byte per cycle while the output register is free or
// being emptied; set by the single output register and its ready handshake.
// Reset: position to byte 0, signature check armed, output empty; the
// header byte store is not reset.
// ----------------------------------------------------------------------------
// ines_header_decoder_top
// Cartridge header decoder: collects 16 bytes and gives one decoded result.
// ----------------------------------------------------------------------------
module ines_header_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	ihd_in_if.sink    hdr,
	ihd_out_if.source res
);
	import ihd_pkg::*;

	logic accept;
	logic last;
	hdr_t snap;
	res_t dec;
	res_t res_q;
	logic res_valid_q;

	// a byte is taken whenever the output slot is free or being emptied
	assign hdr.ready = !res_valid_q || res.ready;
	assign accept    = hdr.valid && hdr.ready;

	ihd_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.hdr_byte  (hdr.hdr_byte),
		.start_req (hdr.start_req),
		.last      (last),
		.hdr       (snap)
	);

	ihd_decode u_decode (
		.hdr (snap),
		.res (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			res_q <= dec;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_q.status;
	assign res.version         = res_q.version;
	assign res.mapper          = res_q.mapper;
	assign res.submapper       = res_q.submapper;
	assign res.prg_rom_bytes   = res_q.prg_rom_bytes;
	assign res.chr_rom_bytes   = res_q.chr_rom_bytes;
	assign res.prg_ram_bytes   = res_q.prg_ram_bytes;
	assign res.prg_nvram_bytes = res_q.prg_nvram_bytes;
	assign res.chr_ram_bytes   = res_q.chr_ram_bytes;
	assign res.chr_nvram_bytes = res_q.chr_nvram_bytes;
	assign res.mirroring       = res_q.mirroring;
	assign res.flags           = res_q.flags;

endmodule

// ----- design/ihd_collect.sv -----
// ----------------------------------------------------------------------------
// ihd_collect
// Tracks the byte position, checks the signature and keeps header bytes.
// ----------------------------------------------------------------------------
module ihd_collect (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    hdr_byte,
	input  logic          start_req,
	output logic          last,
	output ihd_pkg::hdr_t hdr
);
	import ihd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             sig_q;
	logic [POS_W-1:0] pos;
	logic             sig_cur;
	logic             sig_nxt;
	logic [7:0]       store_q [HDR_BYTES-1];

	// start flag overrides the running position
	assign pos     = start_req ? '0 : pos_q;
	assign sig_cur = start_req ? 1'b1 : sig_q;
	assign last    = (pos == POS_LAST);

	always_comb begin
		sig_nxt = sig_cur;
		if (pos < POS_W'(SIG_LEN)) begin
			if (hdr_byte != SIG_BYTES[pos[1:0]]) begin
				sig_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sig_q <= 1'b1;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				sig_q <= 1'b1;
			end else begin
				pos_q <= pos + 1'b1;
				sig_q <= sig_nxt;
			end
		end
	end

	// bytes 4..14 kept; byte 15 is used as it arrives
	for (genvar i = 0; i < HDR_BYTES - 1; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (accept && (pos == POS_W'(i + SIG_LEN))) begin
				store_q[i] <= hdr_byte;
			end
		end
		assign hdr.b[i] = store_q[i];
	end

	assign hdr.b[HDR_BYTES-1] = hdr_byte;
	assign hdr.sig_ok         = sig_cur;

endmodule

// ----- design/ihd_decode.sv -----
// ----------------------------------------------------------------------------
// ihd_decode
// Turns a complete header snapshot into the decoded result fields.
// ----------------------------------------------------------------------------
module ihd_decode (
	input  ihd_pkg::hdr_t hdr,
	output ihd_pkg::res_t res
);
	import ihd_pkg::*;

	logic [7:0] b4, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14, b15;
	logic [1:0] ver;
	logic       battery;
	logic [RAM_W-1:0] ram;

	assign b4  = hdr.b[0];
	assign b5  = hdr.b[1];
	assign b6  = hdr.b[2];
	assign b7  = hdr.b[3];
	assign b8  = hdr.b[4];
	assign b9  = hdr.b[5];
	assign b10 = hdr.b[6];
	assign b11 = hdr.b[7];
	assign b12 = hdr.b[8];
	assign b13 = hdr.b[9];
	assign b14 = hdr.b[10];
	assign b15 = hdr.b[11];

	assign battery = b6[1];

	always_comb begin
		if ((b7[3:0] & VER_MASK) == VER_NES2_ID) begin
			ver = VER_NES2;
		end else if ((b7[3:0] & VER_MASK) == 4'h0 && b12 == 8'h00 && b13 == 8'h00
				&& b14 == 8'h00 && b15 == 8'h00) begin
			ver = VER_INES;
		end else begin
			ver = VER_ARCHAIC;
		end
	end

	// PRG RAM for the older formats; a zero count still means 8 KiB
	always_comb begin
		if (ver == VER_INES && b8 != 8'h00) begin
			ram = {1'b0, b8, 13'h0};
		end else begin
			ram = RAM_8K;
		end
	end

	always_comb begin
		res = '0;
		if (!hdr.sig_ok) begin
			res.status = STATUS_BAD;
		end else begin
			res.status  = STATUS_OK;
			res.version = ver;
			if (ver == VER_NES2) begin
				res.mapper          = {b8[3:0], b7[7:4], b6[7:4]};
				res.submapper       = b9[7:4];
				res.prg_rom_bytes   = {b9[3:0], b4, 14'h0};
				res.chr_rom_bytes   = {b9[7:4], b5, 13'h0};
				res.prg_ram_bytes   = nes2_ram(b10[3:0]);
				res.prg_nvram_bytes = nes2_ram(b10[7:4]);
				res.chr_ram_bytes   = nes2_ram(b11[3:0]);
				res.chr_nvram_bytes = nes2_ram(b11[7:4]);
			end else begin
				if (ver == VER_INES) begin
					res.mapper = {4'h0, b7[7:4], b6[7:4]};
				end else begin
					res.mapper = {8'h00, b6[7:4]};
				end
				res.prg_rom_bytes = {4'h0, b4, 14'h0};
				res.chr_rom_bytes = {4'h0, b5, 13'h0};
				if (battery) begin
					res.prg_nvram_bytes = ram;
				end else begin
					res.prg_ram_bytes = ram;
				end
				res.chr_ram_bytes = (b5 == 8'h00) ? RAM_8K : '0;
			end

			if (b6[3]) begin
				res.mirroring = MIRROR_FOUR;
			end else if (b6[0]) begin
				res.mirroring = MIRROR_VERT;
			end else begin
				res.mirroring = MIRROR_HORZ;
			end

			res.flags = {(ver == VER_NES2) ? b14[1:0] : 2'b00, b6[2], battery};
		end
	end

endmodule

// ----- tb/tb_ines_header_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_ines_header_decoder_top
// Streams cartridge header bytes into the decoder and checks every decoded
// result against a cycle-free predictor of the header rules. Covers NES 2.0,
// iNES 1.0, archaic and corrupt-signature headers, restarts mid-header and
// stray bytes, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ines_header_decoder_top;
	import ihd_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RST_CYCLES = 7;
	localparam int LONG_HOLD  = 200;
	localparam int WD_LIMIT   = 3000;
	localparam int END_WAIT   = 16;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} hdr_beat_t;

	typedef enum int {HK_NES2, HK_INES, HK_ARCHAIC, HK_BADSIG} hdr_kind_t;

	logic clk;
	logic arst_n;

	ihd_in_if  hdr_ch ();
	ihd_out_if res_ch ();

	ines_header_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr_ch),
		.res    (res_ch)
	);

	hdr_beat_t byte_feed [$];
	res_t      pending_decodes [$];
	hdr_beat_t next_beat;

	// predictor state
	logic [3:0] parse_pos;
	logic       sig_match;
	logic [7:0] hdr_bytes [4:15];

	int pushed_total = 0;
	int taken_total  = 0;
	int results_seen = 0;
	int fail_count   = 0;
	int restarts     = 0;
	int n_nes2       = 0;
	int n_ines       = 0;
	int n_archaic    = 0;
	int n_badsig     = 0;
	int src_gap      = 0;
	int sink_stall   = 0;
	int quiet_cycles = 0;

	bit idle_en        = 1'b1;
	bit hold_req       = 1'b0;
	bit hold_done      = 1'b0;
	bit stream_aligned = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [RAM_W-1:0] shift_to_ram_bytes(input logic [3:0] sh);
		logic [RAM_W-1:0] sz;
		sz = (sh == 4'd0) ? '0 : (RAM_W'(64) << sh);
		return sz;
	endfunction

	function automatic res_t build_expected();
		res_t             r;
		logic [7:0]       b4, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14, b15;
		logic [RAM_W-1:0] ram;
		logic             battery;
		logic             tail_zero;
		r = '0;
		if (!sig_match) begin
			r.status = STATUS_BAD;
			return r;
		end
		b4  = hdr_bytes[4];
		b5  = hdr_bytes[5];
		b6  = hdr_bytes[6];
		b7  = hdr_bytes[7];
		b8  = hdr_bytes[8];
		b9  = hdr_bytes[9];
		b10 = hdr_bytes[10];
		b11 = hdr_bytes[11];
		b12 = hdr_bytes[12];
		b13 = hdr_bytes[13];
		b14 = hdr_bytes[14];
		b15 = hdr_bytes[15];
		battery   = b6[1];
		tail_zero = ({b12, b13, b14, b15} == 32'd0);
		r.status  = STATUS_OK;
		if ((b7[3:0] & VER_MASK) == VER_NES2_ID) begin
			r.version = VER_NES2;
		end else if ((b7[3:0] & VER_MASK) == 4'h0 && tail_zero) begin
			r.version = VER_INES;
		end else begin
			r.version = VER_ARCHAIC;
		end
		if (r.version == VER_NES2) begin
			r.mapper          = {b8[3:0], b7[7:4], b6[7:4]};
			r.submapper       = b9[7:4];
			r.prg_rom_bytes   = 26'({b9[3:0], b4}) * 26'd16384;
			r.chr_rom_bytes   = 25'({b9[7:4], b5}) * 25'd8192;
			r.prg_ram_bytes   = shift_to_ram_bytes(b10[3:0]);
			r.prg_nvram_bytes = shift_to_ram_bytes(b10[7:4]);
			r.chr_ram_bytes   = shift_to_ram_bytes(b11[3:0]);
			r.chr_nvram_bytes = shift_to_ram_bytes(b11[7:4]);
			r.flags[3:2]      = b14[1:0];
		end else begin
			if (r.version == VER_INES) begin
				r.mapper = {4'h0, b7[7:4], b6[7:4]};
				// a zero count still means one 8 KiB bank
				ram = (b8 == 8'd0) ? RAM_8K : RAM_W'(b8) * RAM_8K;
			end else begin
				r.mapper = {8'h00, b6[7:4]};
				ram = RAM_8K;
			end
			r.prg_rom_bytes = 26'(b4) * 26'd16384;
			r.chr_rom_bytes = 25'(b5) * 25'd8192;
			if (battery) begin
				r.prg_nvram_bytes = ram;
			end else begin
				r.prg_ram_bytes = ram;
			end
			r.chr_ram_bytes = (b5 == 8'd0) ? RAM_8K : '0;
		end
		if (b6[3]) begin
			r.mirroring = MIRROR_FOUR;
		end else if (b6[0]) begin
			r.mirroring = MIRROR_VERT;
		end else begin
			r.mirroring = MIRROR_HORZ;
		end
		r.flags[0] = battery;
		r.flags[1] = b6[2];
		return r;
	endfunction

	task automatic track_header_byte(input logic [7:0] data, input logic start);
		logic [3:0] p;
		res_t       r;
		if (start) begin
			if (parse_pos != 4'd0)
				restarts++;
			parse_pos = '0;
			sig_match = 1'b1;
		end
		p = parse_pos;
		if (p < SIG_LEN) begin
			if (data != SIG_BYTES[p[1:0]])
				sig_match = 1'b0;
		end else begin
			hdr_bytes[p] = data;
		end
		if (p == POS_LAST) begin
			r = build_expected();
			pending_decodes.push_back(r);
			if (r.status == STATUS_BAD)
				n_badsig++;
			else if (r.version == VER_NES2)
				n_nes2++;
			else if (r.version == VER_INES)
				n_ines++;
			else
				n_archaic++;
			parse_pos = '0;
			sig_match = 1'b1;
		end else begin
			parse_pos = p + 4'd1;
		end
	endtask

	task automatic check_field(input string fname, input logic [25:0] want,
			input logic [25:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", fname, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (pending_decodes.size() == 0) begin
			$error("result transaction with no decode outstanding");
			fail_count++;
		end else begin
			want = pending_decodes.pop_front();
			check_field("status", want.status, res_ch.status);
			check_field("version", want.version, res_ch.version);
			check_field("mapper", want.mapper, res_ch.mapper);
			check_field("submapper", want.submapper, res_ch.submapper);
			check_field("prg_rom_bytes", want.prg_rom_bytes, res_ch.prg_rom_bytes);
			check_field("chr_rom_bytes", want.chr_rom_bytes, res_ch.chr_rom_bytes);
			check_field("prg_ram_bytes", want.prg_ram_bytes, res_ch.prg_ram_bytes);
			check_field("prg_nvram_bytes", want.prg_nvram_bytes, res_ch.prg_nvram_bytes);
			check_field("chr_ram_bytes", want.chr_ram_bytes, res_ch.chr_ram_bytes);
			check_field("chr_nvram_bytes", want.chr_nvram_bytes, res_ch.chr_nvram_bytes);
			check_field("mirroring", want.mirroring, res_ch.mirroring);
			check_field("flags", want.flags, res_ch.flags);
			results_seen++;
		end
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_ch.valid     <= 1'b0;
			hdr_ch.hdr_byte  <= '0;
			hdr_ch.start_req <= 1'b0;
			src_gap   = 0;
			parse_pos = '0;
			sig_match = 1'b1;
		end else begin
			if (hdr_ch.valid && hdr_ch.ready) begin
				track_header_byte(hdr_ch.hdr_byte, hdr_ch.start_req);
				taken_total++;
			end
			if (!hdr_ch.valid || hdr_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					hdr_ch.valid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(1, 15) - 1;
					hdr_ch.valid <= 1'b0;
				end else if (byte_feed.size() > 0) begin
					next_beat = byte_feed.pop_front();
					hdr_ch.valid     <= 1'b1;
					hdr_ch.hdr_byte  <= next_beat.data;
					hdr_ch.start_req <= next_beat.start;
				end else begin
					hdr_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and ready control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (hold_req && !hold_done) begin
				// long hold-off so the output register fills and input backs up
				hold_done  = 1'b1;
				sink_stall = LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				res_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				sink_stall = $urandom_range(1, 15) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WD_LIMIT) begin
				$error("no transaction for %0d cycles", WD_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic push_beat(input logic [7:0] data, input logic start);
		byte_feed.push_back('{data: data, start: start});
		pushed_total++;
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = 8'h00;
			2: v = 8'hFF;
			3: v = 8'($urandom_range(1, 15));
			4: v = {4'($urandom_range(1, 15)), 4'h0};
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	task automatic push_header(input hdr_kind_t kind, input int n_bytes);
		logic [7:0] hb [16];
		int         k;
		logic       first_start;
		for (k = 0; k < 4; k++)
			hb[k] = SIG_BYTES[k];
		for (k = 4; k < 16; k++)
			hb[k] = pick_byte();
		case (kind)
			HK_NES2: hb[7][3:2] = 2'b10;
			HK_INES: begin
				hb[7][3:2] = 2'b00;
				for (k = 12; k < 16; k++)
					hb[k] = 8'h00;
			end
			HK_ARCHAIC: begin
				if ($urandom_range(0, 2) == 0) begin
					// iNES-looking flags but junk in the tail bytes
					hb[7][3:2] = 2'b00;
					k = $urandom_range(12, 15);
					hb[k] = 8'($urandom_range(1, 255));
				end else begin
					hb[7][3:2] = $urandom_range(0, 1) ? 2'b01 : 2'b11;
				end
			end
			HK_BADSIG: begin
				k = $urandom_range(0, 3);
				hb[k] = hb[k] ^ 8'($urandom_range(1, 255));
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, 3);
					hb[k] = 8'($urandom);
				end
			end
		endcase
		first_start = !stream_aligned || ($urandom_range(0, 7) != 0);
		for (k = 0; k < n_bytes; k++)
			push_beat(hb[k], (k == 0) ? first_start : 1'b0);
		stream_aligned = (n_bytes == 16);
	endtask

	task automatic add_random_traffic(input int n_items);
		int made;
		int sel;
		int n;
		made = 0;
		while (made < n_items) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				push_header(HK_NES2, 16);
				made += 16;
			end else if (sel < 60) begin
				push_header(HK_INES, 16);
				made += 16;
			end else if (sel < 75) begin
				push_header(HK_ARCHAIC, 16);
				made += 16;
			end else if (sel < 87) begin
				push_header(HK_BADSIG, 16);
				made += 16;
			end else if (sel < 95) begin
				// cut short; the next header restarts it
				n = $urandom_range(1, 15);
				push_header(hdr_kind_t'($urandom_range(0, 3)), n);
				made += n;
			end else begin
				repeat ($urandom_range(1, 12))
					push_beat(8'($urandom), $urandom_range(0, 7) == 0);
				stream_aligned = 1'b0;
			end
		end
	endtask

	task automatic wait_drained();
		while (taken_total != pushed_total || pending_decodes.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int seg;
		int k;
		clk              = 1'b0;
		arst_n           = 1'b0;
		hdr_ch.valid     = 1'b0;
		hdr_ch.hdr_byte  = '0;
		hdr_ch.start_req = 1'b0;
		res_ch.ready     = 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// partial header dropped by a restart, then a NES 2.0 header of all-ones bytes but byte 7
		for (k = 0; k < 4; k++)
			push_beat(SIG_BYTES[k], k == 0);
		push_beat(8'h00, 1'b0);
		for (k = 0; k < 4; k++)
			push_beat(SIG_BYTES[k], k == 0);
		for (k = 4; k < 16; k++)
			push_beat((k == 7) ? 8'hFB : 8'hFF, 1'b0);
		wait_drained();

		for (seg = 0; seg < 4; seg++) begin
			idle_en = (seg % 2 == 0);
			add_random_traffic((seg % 2 == 0) ? 450 : 200);
			if (seg == 0)
				hold_req = 1'b1;
			wait_drained();
		end
		repeat (END_WAIT) @(negedge clk);

		$display(
			"Checked %0d headers, %0d bytes: %0d NES 2.0, %0d iNES, %0d archaic, %0d bad sig",
			results_seen, taken_total, n_nes2, n_ines, n_archaic, n_badsig);
		$display("Included %0d mid-header restarts, stray bytes and a %0d-cycle output hold-off",
			restarts, LONG_HOLD);
		if (fail_count == 0 && pending_decodes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/ihd_pkg.sv
design/ihd_in_if.sv
design/ihd_out_if.sv
design/ihd_collect.sv
design/ihd_decode.sv
design/ines_header_decoder_top.sv
tb/tb_ines_header_decoder_top.sv
